### hw/rtl/lspd_pkg.sv
// shared types and constants for the lsb stego payload deframer
package lspd_pkg;

    localparam int CARRIER_W        = 8;
    localparam int BYTE_W           = 8;
    localparam int WORD_W           = 32;
    localparam int IDX_W            = 5;
    localparam int LEN_W            = WORD_W - 1;
    localparam int MAGIC_W          = 16;
    localparam int MAGIC_LEN        = 2;
    localparam int MAGIC_BITS       = MAGIC_LEN * BYTE_W;
    localparam int MAX_EXT_LEN_DEF  = 16;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_EXT_LEN = 3'd1,
        PH_EXT     = 3'd2,
        PH_PAY_LEN = 3'd3,
        PH_PAY     = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_EXT    = 2'd0,
        KIND_PAY    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MAGIC_ERR  = 2'd1,
        ST_EXT_LONG   = 2'd2,
        ST_EMPTY_DONE = 2'd3
    } t_status;

    typedef struct packed {
        logic [CARRIER_W-1:0] carrier_byte;
        logic                 restart;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_kind             kind;
        t_status           status;
        logic              last;
    } t_result;

endpackage

### hw/rtl/lspd_in_stage.sv
// input register for carrier words
module lspd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  lspd_pkg::t_in_word i_word,
    input  logic               i_advance,
    output logic               o_valid,
    output lspd_pkg::t_in_word o_word
);
    import lspd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_s_tready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_word <= i_word;
        end
    end

endmodule

### hw/rtl/lspd_frame_fsm.sv
// frame walker: bit gathering, phase tracking and result generation
module lspd_frame_fsm #(
    parameter int MAX_EXT_LEN = lspd_pkg::MAX_EXT_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lspd_pkg::MAGIC_W-1:0] i_cfg_wdata,
    input  logic                         i_take,
    input  lspd_pkg::t_in_word           i_word,
    output logic                         o_res_valid,
    output lspd_pkg::t_result            o_res
);
    import lspd_pkg::*;

    localparam int EXT_W = $clog2(MAX_EXT_LEN + 1);

    t_phase              r_phase,   n_phase;
    logic [IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic [WORD_W-1:0]   r_acc,     n_acc;
    logic [LEN_W-1:0]    r_cnt,     n_cnt;
    logic [EXT_W-1:0]    r_ext_len, n_ext_len;
    logic [LEN_W-1:0]    r_pay_len, n_pay_len;
    logic [MAGIC_W-1:0]  r_magic;

    // state as seen after an optional restart
    t_phase              c_phase;
    logic [IDX_W-1:0]    c_idx;
    logic [WORD_W-1:0]   c_acc;
    logic [LEN_W-1:0]    c_cnt;
    logic [WORD_W-1:0]   acc_new;
    logic [LEN_W-1:0]    cnt_inc;
    logic                done;
    logic                magic_bad;
    logic                ext_long;
    logic                ext_zero;
    logic                pay_empty;
    logic                ext_end;
    logic                pay_end;

    always_comb begin
        if (i_word.restart) begin
            c_phase = PH_MAGIC;
            c_idx   = '0;
            c_acc   = '0;
            c_cnt   = '0;
        end else begin
            c_phase = r_phase;
            c_idx   = r_bit_idx;
            c_acc   = r_acc;
            c_cnt   = r_cnt;
        end
    end

    assign acc_new   = c_acc | (WORD_W'(i_word.carrier_byte[0]) << c_idx);
    assign cnt_inc   = c_cnt + LEN_W'(1);
    assign magic_bad = acc_new[MAGIC_BITS-1:0] != r_magic[MAGIC_BITS-1:0];
    assign ext_long  = acc_new > WORD_W'(MAX_EXT_LEN);
    assign ext_zero  = acc_new == '0;
    assign pay_empty = (acc_new == '0) || acc_new[WORD_W-1];
    assign ext_end   = cnt_inc >= LEN_W'(r_ext_len);
    assign pay_end   = cnt_inc >= r_pay_len;

    always_comb begin
        unique case (c_phase)
            PH_EXT_LEN, PH_PAY_LEN: done = c_idx == IDX_W'(WORD_W - 1);
            PH_MAGIC:               done = c_idx == IDX_W'(MAGIC_BITS - 1);
            PH_EXT, PH_PAY:         done = c_idx == IDX_W'(BYTE_W - 1);
            default:                done = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_phase   = c_phase;
        n_bit_idx = c_idx;
        n_acc     = c_acc;
        n_cnt     = c_cnt;
        n_ext_len = r_ext_len;
        n_pay_len = r_pay_len;
        if (c_phase != PH_IDLE) begin
            if (!done) begin
                n_bit_idx = c_idx + IDX_W'(1);
                n_acc     = acc_new;
            end else begin
                n_bit_idx = '0;
                n_acc     = '0;
                unique case (c_phase)
                    PH_MAGIC: begin
                        n_phase = magic_bad ? PH_IDLE : PH_EXT_LEN;
                    end
                    PH_EXT_LEN: begin
                        n_ext_len = acc_new[EXT_W-1:0];
                        n_cnt     = '0;
                        if (ext_long) begin
                            n_phase = PH_IDLE;
                        end else if (ext_zero) begin
                            n_phase = PH_PAY_LEN;
                        end else begin
                            n_phase = PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        if (ext_end) begin
                            n_phase = PH_PAY_LEN;
                            n_cnt   = '0;
                        end else begin
                            n_cnt   = cnt_inc;
                        end
                    end
                    PH_PAY_LEN: begin
                        n_pay_len = acc_new[LEN_W-1:0];
                        n_cnt     = '0;
                        n_phase   = pay_empty ? PH_IDLE : PH_PAY;
                    end
                    PH_PAY: begin
                        n_cnt = cnt_inc;
                        if (pay_end) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_res_valid     = 1'b0;
        o_res.out_byte  = '0;
        o_res.kind      = KIND_STATUS;
        o_res.status    = ST_OK;
        o_res.last      = 1'b0;
        if (c_phase != PH_IDLE && done) begin
            unique case (c_phase)
                PH_MAGIC: begin
                    o_res_valid  = magic_bad;
                    o_res.status = ST_MAGIC_ERR;
                    o_res.last   = 1'b1;
                end
                PH_EXT_LEN: begin
                    o_res_valid  = ext_long;
                    o_res.status = ST_EXT_LONG;
                    o_res.last   = 1'b1;
                end
                PH_EXT: begin
                    o_res_valid    = 1'b1;
                    o_res.out_byte = acc_new[BYTE_W-1:0];
                    o_res.kind     = KIND_EXT;
                end
                PH_PAY_LEN: begin
                    o_res_valid  = pay_empty;
                    o_res.status = ST_EMPTY_DONE;
                    o_res.last   = 1'b1;
                end
                PH_PAY: begin
                    o_res_valid    = 1'b1;
                    o_res.out_byte = acc_new[BYTE_W-1:0];
                    o_res.kind     = KIND_PAY;
                    o_res.last     = pay_end;
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_bit_idx <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_ext_len <= '0;
            r_pay_len <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_bit_idx <= n_bit_idx;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_ext_len <= n_ext_len;
            r_pay_len <= n_pay_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_wdata;
        end
    end

endmodule

### hw/rtl/lspd_out_stage.sv
// result register toward the master side
module lspd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  lspd_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output lspd_pkg::t_result o_res
);
    import lspd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### hw/rtl/lsb_stego_payload_deframer_core.sv
// top level of the lsb stego payload deframer
// an accepted word is held in the input register; its result is registered in the result register once that can take it
// throughput: one carrier word per cycle while the decoded side takes results, set by the input and result registers
// words that close no field give no result and only advance the bit counter and gather their bit
// reset: synchronous active-low i_rst_n returns to the magic phase, clears counters,
// lengths and the magic register, and empties both register stages
module lsb_stego_payload_deframer_core #(
    parameter int MAX_EXT_LEN = lspd_pkg::MAX_EXT_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // magic word register, first character in the low byte
    input  logic                         i_cfg_we,
    input  logic [lspd_pkg::MAGIC_W-1:0] i_cfg_wdata,
    // carrier side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,  // [7:0] carrier_byte
    input  logic [0:0]                   i_s_tuser,  // [0] restart
    // decoded side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [7:0]                   o_m_tdata,  // [7:0] out_byte
    output logic [3:0]                   o_m_tuser,  // [1:0] kind, [3:2] status
    output logic                         o_m_tlast
);
    import lspd_pkg::*;

    t_in_word in_word;
    t_in_word st_word;
    logic     st_valid;
    logic     out_ready;
    logic     take;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign in_word.carrier_byte = i_s_tdata;
    assign in_word.restart      = i_s_tuser[0];

    // the held word is processed whenever the result register can take its outcome
    assign take = st_valid && out_ready;

    lspd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_word     (in_word),
        .i_advance  (out_ready),
        .o_valid    (st_valid),
        .o_word     (st_word)
    );

    // phase walk, bit gathering and result selection, all in one combinational pass
    lspd_frame_fsm #(
        .MAX_EXT_LEN (MAX_EXT_LEN)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_word      (st_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register keeps a finished word while the next carrier word arrives
    lspd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = out_res.out_byte;
    assign o_m_tuser = {out_res.status, out_res.kind};
    assign o_m_tlast = out_res.last;

endmodule
